/* sv/slab_pkg.sv */
// ============================================================================
// slab_pkg: shared types and constants of the slab object allocator
// Geometry widths, status codes, register indexes and the command and flag
// structs that join the controller and the datapath.
// ============================================================================
`default_nettype none

package slab_pkg;

   localparam int POOL_PAGES = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int MAX_SLOTS  = 512;

   localparam int PAGE_W  = $clog2(POOL_PAGES);
   localparam int SLOT_W  = $clog2(MAX_SLOTS);
   localparam int OFF_W   = $clog2(PAGE_BYTES);
   localparam int ADDR_W  = 18;
   localparam int PAGES_W = 7;
   localparam int SLOTS_W = 10;
   localparam int HEAD_W  = 10;
   // a double free can loop a free list, so the used count may pass the slots
   localparam int USED_W  = 16;
   localparam int LIVE_W  = 15;
   localparam int TALLY_W = 32;
   localparam int CFG_W   = 13;
   localparam int SIZE_W  = 14;
   localparam int FO_W    = 14;
   localparam int DVD_W   = 13;
   localparam int IDX_W   = 2;
   localparam int PROD_W  = SLOT_W + SIZE_W;

   localparam logic [FO_W-1:0]    HDR_BYTES = 14'd24;
   localparam logic [CFG_W-1:0]   MIN_ALIGN = 13'd8;
   localparam logic [HEAD_W-1:0]  NO_SLOT   = 10'd1023;
   localparam logic [CFG_W-1:0]   RST_SIZE  = 13'd8;
   localparam logic [CFG_W-1:0]   RST_ALIGN = 13'd8;
   localparam logic [PAGES_W-1:0] RST_LIMIT = 7'd64;

   localparam logic [IDX_W-1:0] REG_SIZE  = 2'd0;
   localparam logic [IDX_W-1:0] REG_ALIGN = 2'd1;
   localparam logic [IDX_W-1:0] REG_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_PAGE    = 3'd1,
      ST_FOREIGN    = 3'd2,
      ST_UNDERFLOW  = 3'd3,
      ST_BAD_CONFIG = 3'd4
   } status_type;

   typedef struct packed {
      logic       cfg_write;
      logic       geom_start;
      logic       geom_latch;
      logic       req_take;
      logic       scan_load;
      logic       scan_read;
      logic       scan_dec;
      logic       found;
      logic       page_new;
      logic       build_write;
      logic       build_done;
      logic       pop_read;
      logic       pop_write;
      logic       fail;
      logic       free_div;
      logic       free_read;
      logic       free_write;
      logic       set_code;
      status_type code;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic geom_bad;
      logic div_done;
      logic req_free;
      logic scan_zero;
      logic head_hit;
      logic page_full;
      logic build_last;
      logic pre_foreign;
      logic div_foreign;
      logic under;
      logic rsp_open;
   } flags_type;

endpackage

`default_nettype wire

/* sv/slab_channel_if.sv */
// ============================================================================
// slab channel interfaces
// Request, response and register-write channels, each with valid and ready.
// ============================================================================
`default_nettype none

interface slab_req_if;
   import slab_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] address;
   modport source (output valid, op, address, input ready);
   modport sink   (input valid, op, address, output ready);
endinterface

interface slab_rsp_if;
   import slab_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [ADDR_W-1:0]  object_address;
   logic [LIVE_W-1:0]  inuse_count;
   logic [LIVE_W-1:0]  peak_inuse;
   logic [PAGES_W-1:0] pages_taken;
   logic [TALLY_W-1:0] alloc_count;
   logic [TALLY_W-1:0] free_count;
   logic [TALLY_W-1:0] failure_count;
   modport source (output valid, status, object_address, inuse_count, peak_inuse,
                   pages_taken, alloc_count, free_count, failure_count, input ready);
   modport sink   (input valid, status, object_address, inuse_count, peak_inuse,
                   pages_taken, alloc_count, free_count, failure_count, output ready);
endinterface

interface slab_csr_if;
   import slab_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/slab_ram.sv */
// ============================================================================
// slab_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module slab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/slab_div.sv */
// ============================================================================
// slab_div: restoring divider, one quotient bit per cycle
// Gives quotient and remainder of the room after the header, or of a page offset, by the object size.
// ============================================================================
`default_nettype none

module slab_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [slab_pkg::DVD_W-1:0]  dividend,
   input  wire logic [slab_pkg::SIZE_W-1:0] divisor,
   output logic                             done,
   output logic [slab_pkg::DVD_W-1:0]       quotient,
   output logic [slab_pkg::SIZE_W-1:0]      remainder
);
   import slab_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [SIZE_W-1:0] rem_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [SIZE_W:0]   trial;
   logic              fits;

   // one restoring step
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DVD_W);
         rem_ff  <= '0;
         quo_ff  <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* sv/slab_dp.sv */
// ============================================================================
// slab_dp: allocator datapath
// Configuration, geometry, page tables, free lists, counters and the
// response register; acts on the controller's commands.
// ============================================================================
`default_nettype none

module slab_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire slab_pkg::cmd_type            cmd,
   output slab_pkg::flags_type               flags,
   input  wire logic [slab_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [slab_pkg::CFG_W-1:0]   csr_data,
   input  wire logic                         req_op,
   input  wire logic [slab_pkg::ADDR_W-1:0]  req_address,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [slab_pkg::ADDR_W-1:0]       rsp_object_address,
   output logic [slab_pkg::LIVE_W-1:0]       rsp_inuse_count,
   output logic [slab_pkg::LIVE_W-1:0]       rsp_peak_inuse,
   output logic [slab_pkg::PAGES_W-1:0]      rsp_pages_taken,
   output logic [slab_pkg::TALLY_W-1:0]      rsp_alloc_count,
   output logic [slab_pkg::TALLY_W-1:0]      rsp_free_count,
   output logic [slab_pkg::TALLY_W-1:0]      rsp_failure_count
);
   import slab_pkg::*;

   localparam int NEXT_AW = PAGE_W + SLOT_W;

   // configuration
   logic [CFG_W-1:0]   size_cfg_ff, align_cfg_ff;
   logic [PAGES_W-1:0] limit_cfg_ff;
   // geometry
   logic [SIZE_W-1:0]  size_ff;
   logic [FO_W-1:0]    fo_ff;
   logic [SLOTS_W-1:0] slots_ff;
   logic               bad_ff;
   // request and working registers
   logic [PAGE_W-1:0]  page_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [SLOT_W-1:0]  slot_ff, k_ff;
   logic [PAGES_W-1:0] scan_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ADDR_W-1:0]  addr_ff;
   status_type         code_ff;
   // statistics
   logic [PAGES_W-1:0] claimed_ff;
   logic [LIVE_W-1:0]  live_ff, peak_ff, live_in;
   logic [TALLY_W-1:0] alloc_ff, free_ff, fail_ff;
   // response register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [LIVE_W-1:0]  rsp_live_ff, rsp_peak_ff;
   logic [PAGES_W-1:0] rsp_pages_ff;
   logic [TALLY_W-1:0] rsp_alloc_ff, rsp_free_ff, rsp_fail_ff;

   // geometry from the configuration registers
   logic [CFG_W-1:0]   al, al_mask;
   logic               al_pow2;
   logic [SIZE_W-1:0]  size_c;
   logic [FO_W-1:0]    fo_c;
   logic               bad_c;
   logic [FO_W:0]      span_c;
   logic [FO_W-1:0]    room_c;

   assign al      = (align_cfg_ff < MIN_ALIGN) ? MIN_ALIGN : align_cfg_ff;
   assign al_mask = al - 1'b1;
   assign al_pow2 = ((al & al_mask) == '0);
   assign size_c  = (SIZE_W'(size_cfg_ff) + SIZE_W'(al_mask)) & ~SIZE_W'(al_mask);
   assign fo_c    = (HDR_BYTES + FO_W'(al_mask)) & ~FO_W'(al_mask);
   assign span_c  = {1'b0, fo_c} + (FO_W + 1)'(size_c);
   assign bad_c   = (size_cfg_ff == '0) || !al_pow2 || (span_c > (FO_W + 1)'(PAGE_BYTES));
   assign room_c  = FO_W'(PAGE_BYTES) - fo_c;

   // divider, shared by geometry and address decode
   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dvd, div_quo;
   logic [SIZE_W-1:0]  div_rem;
   logic [FO_W-1:0]    off_rel;

   assign off_rel   = FO_W'(off_ff) - fo_ff;
   assign div_start = cmd.geom_start | cmd.free_div;
   assign div_dvd   = cmd.geom_start ? room_c[DVD_W-1:0] : off_rel[DVD_W-1:0];

   slab_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (cmd.geom_start ? size_c : size_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // page tables and free lists
   logic               head_we, used_we, next_we;
   logic [PAGE_W-1:0]  head_raddr;
   logic [HEAD_W-1:0]  head_wdata, head_rdata, next_wdata, next_rdata;
   logic [USED_W-1:0]  used_wdata, used_rdata;
   logic [NEXT_AW-1:0] next_waddr;
   logic [PAGES_W-1:0] scan_prev;

   assign scan_prev  = scan_ff - 1'b1;
   assign head_we    = cmd.build_done | cmd.pop_write | cmd.free_write;
   assign head_raddr = cmd.scan_read ? scan_prev[PAGE_W-1:0] : page_ff;
   always_comb begin
      priority if (cmd.build_done) begin
         head_wdata = slots_ff - 1'b1;
      end else if (cmd.pop_write) begin
         head_wdata = next_rdata;
      end else begin
         head_wdata = HEAD_W'(slot_ff);
      end
   end

   assign used_we = cmd.build_done | cmd.pop_write | cmd.free_write;
   always_comb begin
      priority if (cmd.build_done) begin
         used_wdata = '0;
      end else if (cmd.pop_write) begin
         used_wdata = used_rdata + 1'b1;
      end else begin
         used_wdata = used_rdata - 1'b1;
      end
   end

   assign next_we    = cmd.build_write | cmd.free_write;
   assign next_waddr = cmd.build_write ? {page_ff, k_ff} : {page_ff, slot_ff};
   always_comb begin
      if (cmd.build_write) begin
         next_wdata = (k_ff == '0) ? NO_SLOT : HEAD_W'(k_ff - 1'b1);
      end else begin
         next_wdata = head_rdata;
      end
   end

   slab_ram #(.WIDTH(HEAD_W), .DEPTH(POOL_PAGES)) u_head (
      .clock (clock), .we (head_we), .waddr (page_ff), .wdata (head_wdata),
      .raddr (head_raddr), .rdata (head_rdata)
   );

   slab_ram #(.WIDTH(USED_W), .DEPTH(POOL_PAGES)) u_used (
      .clock (clock), .we (used_we), .waddr (page_ff), .wdata (used_wdata),
      .raddr (page_ff), .rdata (used_rdata)
   );

   slab_ram #(.WIDTH(HEAD_W), .DEPTH(POOL_PAGES * MAX_SLOTS)) u_next (
      .clock (clock), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
      .raddr ({page_ff, slot_ff}), .rdata (next_rdata)
   );

   // configuration and geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff  <= RST_SIZE;
         align_cfg_ff <= RST_ALIGN;
         limit_cfg_ff <= RST_LIMIT;
      end else if (cmd.cfg_write) begin
         unique case (csr_index)
            REG_SIZE:  size_cfg_ff  <= csr_data;
            REG_ALIGN: align_cfg_ff <= csr_data;
            REG_LIMIT: limit_cfg_ff <= csr_data[PAGES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.geom_start) begin
         size_ff <= size_c;
         fo_ff   <= fo_c;
         bad_ff  <= bad_c;
      end
      if (cmd.geom_latch) begin
         slots_ff <= (div_quo > DVD_W'(MAX_SLOTS)) ? SLOTS_W'(MAX_SLOTS)
                                                   : div_quo[SLOTS_W-1:0];
      end
   end

   // request working registers
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         page_ff <= req_address[ADDR_W-1 -: PAGE_W];
         off_ff  <= req_address[OFF_W-1:0];
         addr_ff <= '0;
      end
      if (cmd.scan_load) begin
         scan_ff <= claimed_ff;
      end else if (cmd.scan_dec) begin
         scan_ff <= scan_prev;
      end
      if (cmd.found) begin
         page_ff <= scan_prev[PAGE_W-1:0];
         slot_ff <= head_rdata[SLOT_W-1:0];
      end
      if (cmd.page_new) begin
         page_ff <= claimed_ff[PAGE_W-1:0];
         k_ff    <= '0;
      end
      if (cmd.build_write) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.build_done) begin
         slot_ff <= SLOT_W'(slots_ff - 1'b1);
      end
      if (cmd.free_read) begin
         slot_ff <= div_quo[SLOT_W-1:0];
      end
      if (cmd.pop_read) begin
         prod_ff <= slot_ff * size_ff;
      end
      if (cmd.pop_write) begin
         addr_ff <= ADDR_W'({page_ff, OFF_W'(0)} + (PROD_W + 1)'(fo_ff)
                            + (PROD_W + 1)'(prod_ff));
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
   end

   // statistics; a size or alignment write drops the whole cache
   assign live_in = live_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || (cmd.cfg_write && (csr_index == REG_SIZE || csr_index == REG_ALIGN))) begin
         claimed_ff <= '0;
         live_ff    <= '0;
         peak_ff    <= '0;
         alloc_ff   <= '0;
         free_ff    <= '0;
         fail_ff    <= '0;
      end else begin
         if (cmd.req_take) begin
            if (req_op) begin
               free_ff <= free_ff + 1'b1;
            end else begin
               alloc_ff <= alloc_ff + 1'b1;
            end
         end
         if (cmd.build_done) begin
            claimed_ff <= claimed_ff + 1'b1;
         end
         if (cmd.pop_write) begin
            live_ff <= live_in;
            if (live_in > peak_ff) begin
               peak_ff <= live_in;
            end
         end
         if (cmd.free_write) begin
            live_ff <= live_ff - 1'b1;
         end
         if (cmd.fail) begin
            fail_ff <= fail_ff + 1'b1;
         end
      end
   end

   // response register: load a beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= code_ff;
         rsp_addr_ff   <= addr_ff;
         rsp_live_ff   <= live_ff;
         rsp_peak_ff   <= peak_ff;
         rsp_pages_ff  <= claimed_ff;
         rsp_alloc_ff  <= alloc_ff;
         rsp_free_ff   <= free_ff;
         rsp_fail_ff   <= fail_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_object_address = rsp_addr_ff;
   assign rsp_inuse_count    = rsp_live_ff;
   assign rsp_peak_inuse     = rsp_peak_ff;
   assign rsp_pages_taken    = rsp_pages_ff;
   assign rsp_alloc_count    = rsp_alloc_ff;
   assign rsp_free_count     = rsp_free_ff;
   assign rsp_failure_count  = rsp_fail_ff;

   // status toward the controller
   logic [PAGES_W-1:0] limit_eff;
   assign limit_eff = (limit_cfg_ff > PAGES_W'(POOL_PAGES)) ? PAGES_W'(POOL_PAGES)
                                                            : limit_cfg_ff;

   always_comb begin
      flags.geom_bad    = bad_ff;
      flags.div_done    = div_done;
      flags.req_free    = req_op;
      flags.scan_zero   = (scan_ff == '0);
      flags.head_hit    = (head_rdata < slots_ff);
      flags.page_full   = (claimed_ff >= limit_eff);
      flags.build_last  = (SLOTS_W'(k_ff) == slots_ff - 1'b1);
      flags.pre_foreign = (PAGES_W'(page_ff) >= claimed_ff) || (FO_W'(off_ff) < fo_ff);
      flags.div_foreign = (div_rem != '0) || (div_quo >= DVD_W'(slots_ff));
      flags.under       = (used_rdata == '0) || (live_ff == '0);
      flags.rsp_open    = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

/* sv/slab_ctrl.sv */
// ============================================================================
// slab_ctrl: allocator sequencer
// Walks geometry setup, page scan, page build, pop, address decode and push,
// and hands one beat at a time to the response register.
// ============================================================================
`default_nettype none

module slab_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire slab_pkg::flags_type flags,
   output slab_pkg::cmd_type        cmd
);
   import slab_pkg::*;

   typedef enum logic [3:0] {
      S_GEOM, S_GEOM_WAIT, S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_NEW, S_BUILD,
      S_POP_RD, S_POP_WR, S_FCHK, S_FDIV, S_FRD, S_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_GEOM;
      end else begin
         state_ff <= state_in;
      end
   end

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_OK;
      unique case (state_ff)
         S_GEOM: begin
            cmd.geom_start = 1'b1;
            state_in       = S_GEOM_WAIT;
         end
         S_GEOM_WAIT: begin
            if (flags.div_done) begin
               cmd.geom_latch = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               state_in      = S_GEOM;
            end else if (req_valid) begin
               cmd.req_take = 1'b1;
               if (flags.geom_bad) begin
                  cmd.set_code = 1'b1;
                  cmd.code     = ST_BAD_CONFIG;
                  state_in     = S_RESULT;
               end else if (flags.req_free) begin
                  state_in = S_FCHK;
               end else begin
                  cmd.scan_load = 1'b1;
                  state_in      = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (flags.scan_zero) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (flags.head_hit) begin
               cmd.found = 1'b1;
               state_in  = S_POP_RD;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_NEW: begin
            if (flags.page_full) begin
               cmd.fail     = 1'b1;
               cmd.set_code = 1'b1;
               cmd.code     = ST_NO_PAGE;
               state_in     = S_RESULT;
            end else begin
               cmd.page_new = 1'b1;
               state_in     = S_BUILD;
            end
         end
         S_BUILD: begin
            cmd.build_write = 1'b1;
            if (flags.build_last) begin
               cmd.build_done = 1'b1;
               state_in       = S_POP_RD;
            end
         end
         S_POP_RD: begin
            cmd.pop_read = 1'b1;
            state_in     = S_POP_WR;
         end
         S_POP_WR: begin
            cmd.pop_write = 1'b1;
            cmd.set_code  = 1'b1;
            cmd.code      = ST_OK;
            state_in      = S_RESULT;
         end
         S_FCHK: begin
            if (flags.pre_foreign) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_FOREIGN;
               state_in     = S_RESULT;
            end else begin
               cmd.free_div = 1'b1;
               state_in     = S_FDIV;
            end
         end
         S_FDIV: begin
            if (flags.div_done) begin
               if (flags.div_foreign) begin
                  cmd.set_code = 1'b1;
                  cmd.code     = ST_FOREIGN;
                  state_in     = S_RESULT;
               end else begin
                  cmd.free_read = 1'b1;
                  state_in      = S_FRD;
               end
            end
         end
         S_FRD: begin
            cmd.set_code = 1'b1;
            if (flags.under) begin
               cmd.code = ST_UNDERFLOW;
            end else begin
               cmd.free_write = 1'b1;
               cmd.code       = ST_OK;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (flags.rsp_open) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* sv/slab_object_allocator_top.sv */
// ============================================================================
// slab_object_allocator_top: fixed-size object allocator over pool pages
// Hands out and takes back equal-size objects over 64 pages of 4 KiB.
// ============================================================================
// Usage:
//  - csr_bus writes requested_size (index 0), requested_align (1) or
//    page_limit (2). Size or alignment writes drop all pages and statistics.
//    After any write and after reset the geometry divider runs with
//    req_bus.ready low.
//  - req_bus carries op (0 allocate, 1 free) and address; each beat gives one
//    rsp_bus beat with status, object address and the statistics.
//  - Items are handled one at a time. Allocate scans the claimed pages newest
//    first over the page-head RAM; when no page has room it builds the free
//    list of a fresh page and takes its slot, or fails when out of pages.
//    Free checks the address against the claimed pages, then decodes it with
//    the 13-step offset divider. Bad configuration skips scan and decode.
//  - The response register holds a finished beat while rsp_bus stalls; the
//    next request is accepted meanwhile and waits in its last step.
//  - Reset is synchronous; configuration returns to size 8, align 8, limit 64.
// ============================================================================
`default_nettype none

module slab_object_allocator_top (
   input  wire logic clock,
   input  wire logic reset,
   slab_req_if.sink  req_bus,
   slab_rsp_if.source rsp_bus,
   slab_csr_if.sink  csr_bus
);
   import slab_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   slab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   slab_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .flags              (flags),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .req_op             (req_bus.op),
      .req_address        (req_bus.address),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_status         (rsp_bus.status),
      .rsp_object_address (rsp_bus.object_address),
      .rsp_inuse_count    (rsp_bus.inuse_count),
      .rsp_peak_inuse     (rsp_bus.peak_inuse),
      .rsp_pages_taken    (rsp_bus.pages_taken),
      .rsp_alloc_count    (rsp_bus.alloc_count),
      .rsp_free_count     (rsp_bus.free_count),
      .rsp_failure_count  (rsp_bus.failure_count)
   );

endmodule

`default_nettype wire

/* sv/slab_checker.sv */
// ============================================================================
// slab_checker: port-level checks of the slab allocator
// Watches the request and response channels and is bound to the top level.
// ============================================================================
`default_nettype none

module slab_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [2:0]                   rsp_status,
   input wire logic [slab_pkg::ADDR_W-1:0]  rsp_object_address,
   input wire logic [slab_pkg::PAGES_W-1:0] rsp_pages_taken
);
   import slab_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_object_address)
                                  && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // one item at a time: no back-to-back request beats
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // only a successful allocate carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_object_address == '0)
      else $error("failed request returned an address");

   // claimed pages stay within the pool
   a_pages: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pages_taken <= PAGES_W'(POOL_PAGES))
      else $error("pages taken beyond the pool");

endmodule

bind slab_object_allocator_top slab_checker u_slab_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_object_address (rsp_bus.object_address),
   .rsp_pages_taken    (rsp_bus.pages_taken)
);

`default_nettype wire

/* tb/tb.sv */
// ============================================================================
// tb: self-checking bench for the slab object allocator
// Drives allocate and free requests through several geometry and page-limit
// settings, predicts every response beat and compares it field by field.
// ============================================================================
`default_nettype none

module tb;
   import slab_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic              op;
      logic [ADDR_W-1:0] address;
   } req_item_type;

   typedef struct {
      status_type         status;
      logic [ADDR_W-1:0]  object_address;
      logic [LIVE_W-1:0]  inuse_count;
      logic [LIVE_W-1:0]  peak_inuse;
      logic [PAGES_W-1:0] pages_taken;
      logic [TALLY_W-1:0] alloc_count;
      logic [TALLY_W-1:0] free_count;
      logic [TALLY_W-1:0] failure_count;
   } rsp_item_type;

   logic clock;
   logic reset;

   slab_req_if req_bus();
   slab_rsp_if rsp_bus();
   slab_csr_if csr_bus();

   slab_object_allocator_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   // configuration copy and derived geometry
   logic [CFG_W-1:0]   obj_size_reg;
   logic [CFG_W-1:0]   obj_align_reg;
   logic [PAGES_W-1:0] limit_reg;
   bit                 geom_ok;
   int unsigned        geom_first;
   int unsigned        geom_size;
   int unsigned        geom_slots;

   // allocator state copy
   logic [HEAD_W-1:0]  next_slot[POOL_PAGES*MAX_SLOTS];
   logic [HEAD_W-1:0]  free_head[POOL_PAGES];
   logic [USED_W-1:0]  used_slots[POOL_PAGES];
   int unsigned        pages_claimed;
   logic [LIVE_W-1:0]  live_cnt;
   logic [LIVE_W-1:0]  live_max;
   logic [TALLY_W-1:0] allocs_seen;
   logic [TALLY_W-1:0] frees_seen;
   logic [TALLY_W-1:0] fails_seen;

   int  sender_idle_pct;
   int  recv_stall_pct;
   int  recv_hold;
   bit  failed;
   int  cycles;

   // derive object geometry from size and alignment
   function automatic void update_geometry();
      int unsigned al;
      al = (obj_align_reg < MIN_ALIGN) ? MIN_ALIGN : obj_align_reg;
      geom_ok = 1'b0;
      if ((al & (al - 1)) != 0 || obj_size_reg == 0) return;
      geom_size  = (obj_size_reg + al - 1) & ~(al - 1);
      geom_first = (HDR_BYTES + al - 1) & ~(al - 1);
      if (geom_first + geom_size > PAGE_BYTES) return;
      geom_slots = (PAGE_BYTES - geom_first) / geom_size;
      if (geom_slots > MAX_SLOTS) geom_slots = MAX_SLOTS;
      geom_ok = 1'b1;
   endfunction

   function automatic void drop_cache();
      pages_claimed = 0;
      live_cnt      = '0;
      live_max      = '0;
      allocs_seen   = '0;
      frees_seen    = '0;
      fails_seen    = '0;
   endfunction

   function automatic void apply_csr(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
         REG_SIZE: begin
            obj_size_reg = val;
            drop_cache();
         end
         REG_ALIGN: begin
            obj_align_reg = val;
            drop_cache();
         end
         REG_LIMIT: begin
            limit_reg = val[PAGES_W-1:0];
         end
         default: ;
      endcase
      update_geometry();
   endfunction

   // allocate: newest page with a free slot, else claim a fresh page
   function automatic status_type alloc_object(output logic [ADDR_W-1:0] addr);
      int unsigned lim, pg, sl, k;
      bit hit;
      lim = (limit_reg < POOL_PAGES) ? limit_reg : POOL_PAGES;
      hit = 1'b0;
      pg  = 0;
      addr = '0;
      for (int i = pages_claimed; i > 0; i--) begin
         if (free_head[i-1] < geom_slots) begin
            pg  = i - 1;
            hit = 1'b1;
            break;
         end
      end
      if (!hit) begin
         if (pages_claimed >= lim) begin
            fails_seen++;
            return ST_NO_PAGE;
         end
         pg = pages_claimed;
         for (k = 0; k < geom_slots; k++)
            next_slot[pg*MAX_SLOTS+k] = (k == 0) ? NO_SLOT : HEAD_W'(k - 1);
         free_head[pg]  = HEAD_W'(geom_slots - 1);
         used_slots[pg] = '0;
         pages_claimed++;
      end
      sl = free_head[pg];
      free_head[pg] = next_slot[pg*MAX_SLOTS+sl];
      used_slots[pg]++;
      live_cnt++;
      if (live_cnt > live_max) live_max = live_cnt;
      addr = ADDR_W'(pg*PAGE_BYTES + geom_first + sl*geom_size);
      return ST_OK;
   endfunction

   // free: map address to page and slot, push the slot back
   function automatic status_type free_object(logic [ADDR_W-1:0] addr);
      int unsigned pg, off, sl;
      pg  = addr / PAGE_BYTES;
      off = addr % PAGE_BYTES;
      if (pg >= pages_claimed || off < geom_first || (off - geom_first) % geom_size != 0)
         return ST_FOREIGN;
      sl = (off - geom_first) / geom_size;
      if (sl >= geom_slots) return ST_FOREIGN;
      if (used_slots[pg] == 0 || live_cnt == 0) return ST_UNDERFLOW;
      next_slot[pg*MAX_SLOTS+sl] = free_head[pg];
      free_head[pg] = HEAD_W'(sl);
      used_slots[pg]--;
      live_cnt--;
      return ST_OK;
   endfunction

   function automatic rsp_item_type predict_rsp(req_item_type rq);
      rsp_item_type r;
      logic [ADDR_W-1:0] a;
      a = '0;
      if (rq.op == 1'b0) begin
         allocs_seen++;
         r.status = geom_ok ? alloc_object(a) : ST_BAD_CONFIG;
      end else begin
         frees_seen++;
         r.status = geom_ok ? free_object(rq.address) : ST_BAD_CONFIG;
      end
      r.object_address = a;
      r.inuse_count    = live_cnt;
      r.peak_inuse     = live_max;
      r.pages_taken    = PAGES_W'(pages_claimed);
      r.alloc_count    = allocs_seen;
      r.free_count     = frees_seen;
      r.failure_count  = fails_seen;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(int unsigned pg, int unsigned sl);
      return ADDR_W'(pg*PAGE_BYTES + geom_first + sl*geom_size);
   endfunction

   // random request: mostly plausible slot addresses, some near misses and noise
   function automatic req_item_type random_req(int alloc_pct);
      req_item_type rq;
      int unsigned pick, pg, sl;
      rq.op = ($urandom_range(99) < alloc_pct) ? 1'b0 : 1'b1;
      rq.address = ADDR_W'($urandom);
      pick = $urandom_range(99);
      if (geom_ok && pick < 75) begin
         pg = $urandom_range(limit_reg < POOL_PAGES ? limit_reg : POOL_PAGES - 1);
         sl = $urandom_range(geom_slots);
         rq.address = slot_addr(pg, sl);
      end else if (geom_ok && pick < 88) begin
         pg = $urandom_range(3);
         rq.address = ADDR_W'(slot_addr(pg, $urandom_range(geom_slots))
                              + $urandom_range(1, 7));
      end
      return rq;
   endfunction

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[slab_object_allocator_top] ERROR");
         $finish;
      end
   end

   // request driver: present the next beat once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.op      <= pending_reqs[0].op;
            req_bus.address <= pending_reqs[0].address;
            void'(pending_reqs.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted request beat
   always @(posedge clock) begin
      req_item_type rq;
      if (!reset && req_bus.valid && req_bus.ready) begin
         rq.op      = req_bus.op;
         rq.address = req_bus.address;
         expected_rsps.push_back(predict_rsp(rq));
      end
   end

   // response ready: random stalls plus a long hold while recv_hold runs down
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         recv_hold     <= recv_hold - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d", $time, rsp_bus.status);
            failed = 1'b1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_bus.status !== e.status || rsp_bus.object_address !== e.object_address ||
                rsp_bus.inuse_count !== e.inuse_count || rsp_bus.peak_inuse !== e.peak_inuse ||
                rsp_bus.pages_taken !== e.pages_taken ||
                rsp_bus.alloc_count !== e.alloc_count ||
                rsp_bus.free_count !== e.free_count ||
                rsp_bus.failure_count !== e.failure_count) begin
               $display("%0t: mismatch expected st=%0d adr=%h use=%0d pk=%0d pg=%0d a=%0d f=%0d x=%0d",
                        $time, e.status, e.object_address, e.inuse_count, e.peak_inuse,
                        e.pages_taken, e.alloc_count, e.free_count, e.failure_count);
               $display("%0t:          actual   st=%0d adr=%h use=%0d pk=%0d pg=%0d a=%0d f=%0d x=%0d",
                        $time, rsp_bus.status, rsp_bus.object_address, rsp_bus.inuse_count,
                        rsp_bus.peak_inuse, rsp_bus.pages_taken, rsp_bus.alloc_count,
                        rsp_bus.free_count, rsp_bus.failure_count);
               failed = 1'b1;
            end
         end
      end
   end

   // wait until every queued request has been answered
   task automatic drain();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      apply_csr(idx, val);
   endtask

   task automatic push_req(logic op, logic [ADDR_W-1:0] addr);
      req_item_type rq;
      rq.op      = op;
      rq.address = addr;
      pending_reqs.push_back(rq);
   endtask

   task automatic run_phase(logic [CFG_W-1:0] sz, logic [CFG_W-1:0] al,
                            logic [CFG_W-1:0] lim, int n, int alloc_pct, int mode);
      drain();
      write_csr(REG_SIZE, sz);
      write_csr(REG_ALIGN, al);
      write_csr(REG_LIMIT, lim);
      case (mode % 4)
         0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
         default: begin sender_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(alloc_pct));
   endtask

   initial begin
      failed          = 1'b0;
      cycles          = 0;
      recv_hold       = 0;
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = 1'b0;
      req_bus.address = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_SIZE;
      csr_bus.data    = '0;
      obj_size_reg    = RST_SIZE;
      obj_align_reg   = RST_ALIGN;
      limit_reg       = RST_LIMIT;
      drop_cache();
      update_geometry();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, allocate, double free, underflow, foreign
      push_req(1'b1, slot_addr(0, 0));
      push_req(1'b0, '0);
      push_req(1'b0, '1);
      push_req(1'b1, slot_addr(0, geom_slots - 1));
      push_req(1'b1, slot_addr(0, geom_slots - 1));
      push_req(1'b1, slot_addr(0, geom_slots - 1));
      push_req(1'b1, '0);
      push_req(1'b1, '1);
      push_req(1'b1, ADDR_W'(PAGE_BYTES + geom_first));
      push_req(1'b1, ADDR_W'(geom_first + 1));
      push_req(1'b0, '0);
      push_req(1'b1, slot_addr(0, geom_slots - 2));
      drain();

      // exhaust a tiny limit, then lower it to zero and raise it without dropping pages
      write_csr(REG_SIZE, 13'd4072);
      write_csr(REG_LIMIT, 7'd2);
      for (int i = 0; i < 4; i++) push_req(1'b0, '0);
      push_req(1'b1, slot_addr(1, 0));
      push_req(1'b1, slot_addr(1, 1));
      drain();
      write_csr(REG_LIMIT, 7'd0);
      push_req(1'b0, '0);
      push_req(1'b0, '0);
      drain();
      write_csr(REG_LIMIT, 7'd127);
      push_req(1'b0, '0);
      push_req(1'b0, '0);
      drain();

      // random phases over geometry and limit extremes
      run_phase(13'd8, 13'd8, 7'd64, 160, 60, 0);
      run_phase(13'd1, 13'd0, 7'd1, 160, 55, 1);
      run_phase(13'd4096, 13'd0, 7'd64, 40, 50, 2);
      run_phase(13'd2048, 13'd4096, 7'd64, 40, 50, 3);
      run_phase(13'd100, 13'd64, 7'd4, 170, 60, 0);
      recv_hold = 400;
      run_phase(13'd13, 13'd3, 7'd5, 40, 50, 1);
      run_phase(13'd0, 13'd16, 7'd5, 40, 50, 2);
      run_phase(13'd1000, 13'd16, 7'd7, 180, 60, 3);
      run_phase(13'd4072, 13'd1, 7'd3, 150, 60, 2);
      run_phase(13'd24, 13'd16, 7'd64, 170, 55, 0);
      run_phase(13'd8191, 13'd8191, 7'd64, 30, 50, 1);
      run_phase(13'd512, 13'd512, 7'd6, 180, 60, 3);
      run_phase(13'd2032, 13'd8, 7'd127, 160, 60, 2);
      drain();

      if (!failed) begin
         $display("[slab_object_allocator_top] OK");
      end else begin
         $display("[slab_object_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
